// ===== design/npr_pkg.sv =====
// Shared types, codes and node selection functions for the NUMA policy node resolver.
package npr_pkg;

  localparam int MAX_NODES      = 16;
  localparam int TASK_SLOTS_DEF = 64;

  localparam logic [1:0] REQ_RESOLVE = 2'd0;
  localparam logic [1:0] REQ_SET     = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  localparam logic [2:0] MODE_NONE           = 3'd0;
  localparam logic [2:0] MODE_PREFERRED      = 3'd1;
  localparam logic [2:0] MODE_BIND           = 3'd2;
  localparam logic [2:0] MODE_INTERLEAVE     = 3'd3;
  localparam logic [2:0] MODE_LOCAL          = 3'd4;
  localparam logic [2:0] MODE_PREFERRED_MANY = 3'd5;
  localparam logic [2:0] MODE_WEIGHTED       = 3'd6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_VDIV,
    S_VPICK,
    S_TDIV,
    S_TPICK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] mask;
    logic [3:0]  cursor;
  } entry_t;

  typedef struct packed {
    logic       found;
    logic [3:0] idx;
  } lowest_t;

  typedef struct packed {
    logic       found;
    logic [3:0] node;
    logic       strict;
    logic       adv;
    logic [3:0] cursor;
  } pick_t;

  // Mask with the low cnt bits set, cnt from 0 to 16.
  function automatic logic [15:0] low_mask(input logic [4:0] cnt);
    logic [16:0] m;
    m = (17'd1 << cnt) - 17'd1;
    return m[15:0];
  endfunction

  // Lowest set bit below MAX_NODES.
  function automatic lowest_t lowest_node(input logic [15:0] mask);
    lowest_t     r;
    logic [15:0] m;
    m = mask & low_mask(5'(MAX_NODES));
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) begin
        r.found = 1'b1;
        r.idx   = 4'(i);
      end
    end
    return r;
  endfunction

  // One policy lookup. The interleave search starts at start, which is already below n.
  function automatic pick_t pick_node(input logic [2:0]  mode,
                                      input logic [15:0] mask,
                                      input logic [3:0]  start,
                                      input logic [4:0]  n,
                                      input logic [3:0]  local_nd);
    pick_t       r;
    lowest_t     lo;
    lowest_t     lo_hi;
    lowest_t     lo_all;
    logic [15:0] m;
    logic [15:0] hi;
    logic [4:0]  nxt;
    r      = '0;
    lo     = lowest_node(mask);
    m      = mask & low_mask(n);
    hi     = m & ~low_mask({1'b0, start});
    lo_hi  = lowest_node(hi);
    lo_all = lowest_node(m);
    nxt    = '0;
    case (mode)
      MODE_BIND: begin
        r.strict = 1'b1;
        r.found  = lo.found;
        r.node   = lo.found ? lo.idx : 4'd0;
      end
      MODE_PREFERRED, MODE_PREFERRED_MANY: begin
        if (mask != '0) begin
          r.found = lo.found;
          r.node  = lo.found ? lo.idx : 4'd0;
        end else begin
          r.found = 1'b1;
          r.node  = local_nd;
        end
      end
      MODE_INTERLEAVE, MODE_WEIGHTED: begin
        r.found  = lo_all.found;
        r.adv    = lo_all.found;
        r.node   = lo_hi.found ? lo_hi.idx : lo_all.idx;
        nxt      = {1'b0, r.node} + 5'd1;
        r.cursor = (nxt == n) ? 4'd0 : nxt[3:0];
      end
      MODE_LOCAL: begin
        r.found = 1'b1;
        r.node  = local_nd;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== design/npr_channels.sv =====
// Valid/ready channel interfaces for the request and result items.
interface npr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  task_slot;
  logic [2:0]  vma_mode;
  logic [15:0] vma_nodes;
  logic [4:0]  vma_home;
  logic [15:0] page_number;
  logic [3:0]  local_node;
  logic [2:0]  policy_mode;
  logic [15:0] policy_nodes;

  modport source (
    output valid, req_type, task_slot, vma_mode, vma_nodes, vma_home, page_number,
           local_node, policy_mode, policy_nodes,
    input  ready
  );
  modport sink (
    input  valid, req_type, task_slot, vma_mode, vma_nodes, vma_home, page_number,
           local_node, policy_mode, policy_nodes,
    output ready
  );
endinterface

interface npr_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] node;
  logic       node_chosen;
  logic       strict;

  modport source (output valid, node, node_chosen, strict, input ready);
  modport sink (input valid, node, node_chosen, strict, output ready);
endinterface

// ===== design/numa_policy_node_resolver_top.sv =====
// NUMA policy node resolver: picks the memory node for each page allocation request.
//
//   Channel   Dir  Handshake       Payload
//   request   in   valid / ready   req_type, task_slot, vma_*, page_number, local_node,
//                                  policy_mode, policy_nodes
//   result    out  valid / ready   node, node_chosen, strict
//   cfg       in   cfg_we          cfg_wdata = node_count
//
// Set, clear and unused requests, and resolves with fewer than two nodes, go straight to
// the done state. A resolve finds the page number modulo the node count with a restoring
// remainder unit, one dividend bit per cycle across all 16 bits; at the task stage it
// reduces the stored cursor (4 bits) before the pick, and the cursor after the pick is
// written back. After reset a clearing pass zeroes the task table; no item is taken
// during it. The result sits in an output register, so a new item is accepted while the
// previous result still waits; a held result stalls only the next finish.
module numa_policy_node_resolver_top #(
  parameter int TASK_SLOTS = npr_pkg::TASK_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata,
  npr_req_if.sink      request,
  npr_res_if.source    result
);

  localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  npr_pkg::state_t state, state_next;

  logic [4:0]    node_count;
  logic [4:0]    n_eff;
  logic [AW-1:0] clr_cnt;

  // The task table: mode, mask and interleave cursor for each slot.
  npr_pkg::entry_t mem [TASK_SLOTS];
  npr_pkg::entry_t rd_entry;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  npr_pkg::entry_t mem_wdata;
  logic            mem_re;

  logic [AW+5:0] slot_wide;
  logic [AW-1:0] req_idx;
  logic          req_slot_ok;

  // Fields of the item in flight.
  logic [AW-1:0] q_idx;
  logic          q_slot_ok;
  logic [2:0]    q_vmode;
  logic [15:0]   q_vmask;
  logic [4:0]    q_vhome;
  logic [3:0]    q_local;

  // Remainder unit.
  logic [4:0]  div_rem;
  logic [15:0] div_sr;
  logic [4:0]  div_cnt;
  logic        div_start;
  logic [15:0] div_dividend;
  logic [4:0]  div_len;
  logic [5:0]  div_trial;

  logic       pend_load;
  logic [3:0] pend_node, pend_node_next;
  logic       pend_chosen, pend_chosen_next;
  logic       pend_strict, pend_strict_next;

  logic       out_valid;
  logic [3:0] out_node;
  logic       out_chosen;
  logic       out_strict;
  logic       out_load;

  logic           in_ready;
  logic           accept;
  npr_pkg::pick_t vpick;
  npr_pkg::pick_t tpick;
  logic           home_ok;
  logic [4:0]     home_m1;
  logic           go_task;

  assign request.ready      = in_ready;
  assign accept             = request.valid && in_ready;
  assign result.valid       = out_valid;
  assign result.node        = out_node;
  assign result.node_chosen = out_chosen;
  assign result.strict      = out_strict;

  // Node counts above the supported maximum behave as the maximum.
  assign n_eff = (node_count > 5'(npr_pkg::MAX_NODES)) ? 5'(npr_pkg::MAX_NODES) : node_count;

  assign slot_wide   = {{AW{1'b0}}, request.task_slot};
  assign req_idx     = slot_wide[AW-1:0];
  assign req_slot_ok = 32'(request.task_slot) < 32'(TASK_SLOTS);

  // The mapping interleave starts at page_number mod n; an empty mask starts at zero.
  assign vpick = npr_pkg::pick_node(q_vmode, q_vmask,
                                    (q_vmask != '0) ? div_rem[3:0] : 4'd0,
                                    n_eff, q_local);
  assign tpick = npr_pkg::pick_node(rd_entry.mode, rd_entry.mask, div_rem[3:0],
                                    n_eff, q_local);

  assign home_ok = (q_vhome != 5'd0) && (q_vhome <= 5'(npr_pkg::MAX_NODES));
  assign home_m1 = q_vhome - 5'd1;
  assign go_task = !vpick.found && !home_ok && q_slot_ok &&
                   (rd_entry.mode != npr_pkg::MODE_NONE);

  // Shift in the next dividend bit; the partial remainder stays below n.
  assign div_trial = {div_rem, div_sr[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 5'd1;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npr_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == npr_pkg::S_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_entry <= mem[req_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_idx     <= req_idx;
      q_slot_ok <= req_slot_ok;
      q_vmode   <= request.vma_mode;
      q_vmask   <= request.vma_nodes;
      q_vhome   <= request.vma_home;
      q_local   <= request.local_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_start) begin
      div_cnt <= div_len;
    end else if (div_cnt != 5'd0) begin
      div_cnt <= div_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem <= '0;
      div_sr  <= div_dividend;
    end else if (div_cnt != 5'd0) begin
      div_rem <= (div_trial >= {1'b0, n_eff}) ? 5'(div_trial - {1'b0, n_eff})
                                              : div_trial[4:0];
      div_sr  <= {div_sr[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_node   <= pend_node_next;
      pend_chosen <= pend_chosen_next;
      pend_strict <= pend_strict_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_node   <= pend_node;
      out_chosen <= pend_chosen;
      out_strict <= pend_strict;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      npr_pkg::S_CLEAR: begin
        if (clr_cnt == AW'(TASK_SLOTS - 1)) begin
          state_next = npr_pkg::S_IDLE;
        end
      end
      npr_pkg::S_IDLE: begin
        if (accept) begin
          if (request.req_type == npr_pkg::REQ_RESOLVE && n_eff > 5'd1) begin
            state_next = npr_pkg::S_VDIV;
          end else begin
            state_next = npr_pkg::S_DONE;
          end
        end
      end
      npr_pkg::S_VDIV: begin
        if (div_cnt == 5'd1) begin
          state_next = npr_pkg::S_VPICK;
        end
      end
      npr_pkg::S_VPICK: begin
        state_next = go_task ? npr_pkg::S_TDIV : npr_pkg::S_DONE;
      end
      npr_pkg::S_TDIV: begin
        if (div_cnt == 5'd1) begin
          state_next = npr_pkg::S_TPICK;
        end
      end
      npr_pkg::S_TPICK: begin
        state_next = npr_pkg::S_DONE;
      end
      npr_pkg::S_DONE: begin
        if (out_load) begin
          state_next = npr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = npr_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = q_idx;
    mem_wdata        = '0;
    mem_re           = 1'b0;
    div_start        = 1'b0;
    div_dividend     = request.page_number;
    div_len          = 5'd16;
    pend_load        = 1'b0;
    pend_node_next   = 4'd0;
    pend_chosen_next = 1'b0;
    pend_strict_next = 1'b0;
    out_load         = 1'b0;
    case (state)
      npr_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      npr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          // Every non-resolve item, and a resolve with fewer than two nodes, returns all zeros.
          pend_load = 1'b1;
          mem_re    = 1'b1;
          div_start = 1'b1;
          mem_waddr = req_idx;
          if (request.req_type == npr_pkg::REQ_SET && req_slot_ok) begin
            mem_we    = 1'b1;
            mem_wdata = '{mode: request.policy_mode, mask: request.policy_nodes,
                          cursor: 4'd0};
          end else if (request.req_type == npr_pkg::REQ_CLEAR && req_slot_ok) begin
            mem_we = 1'b1;
          end
        end
      end
      npr_pkg::S_VPICK: begin
        pend_load        = 1'b1;
        pend_chosen_next = vpick.found || home_ok;
        pend_strict_next = vpick.strict;
        if (vpick.found) begin
          pend_node_next = vpick.node;
        end else if (home_ok) begin
          pend_node_next = home_m1[3:0];
        end
        if (go_task) begin
          // A cursor left from an older node count may be out of range: reduce it too.
          div_start    = 1'b1;
          div_dividend = {rd_entry.cursor, 12'd0};
          div_len      = 5'd4;
        end
      end
      npr_pkg::S_TPICK: begin
        pend_load        = 1'b1;
        pend_chosen_next = tpick.found;
        pend_node_next   = tpick.found ? tpick.node : 4'd0;
        pend_strict_next = pend_strict || tpick.strict;
        mem_we           = 1'b1;
        mem_wdata        = '{mode: rd_entry.mode, mask: rd_entry.mask,
                             cursor: tpick.adv ? tpick.cursor : rd_entry.cursor};
      end
      npr_pkg::S_DONE: begin
        out_load = !out_valid || result.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== tb/numa_policy_node_resolver_top_tb.sv =====
// Self-checking testbench for the NUMA policy node resolver top level.
`timescale 1ns / 100ps

module numa_policy_node_resolver_top_tb;

  // The request type with no function and the mode with no policy behind it
  // have no names in the package, so they are named here.
  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam logic [2:0] MODE_RESERVED = 3'd7;

  // The drain wait covers the block's longest run, a resolve that reaches
  // the task stage, with margin.
  localparam int SETTLE_CYCLES    = 40;
  // The watchdog limit lies well above the slowest correct run.
  localparam int CYCLE_LIMIT      = 600000;
  localparam int RANDOM_PER_PHASE = 142;
  localparam int REPORT_LINES     = 40;

  // One allocation request item as it goes onto the request channel.
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [2:0]  vmode;
    logic [15:0] vmask;
    logic [4:0]  vhome;
    logic [15:0] page;
    logic [3:0]  local_nd;
    logic [2:0]  pmode;
    logic [15:0] pmask;
  } alloc_req_t;

  // One placement decision as it comes off the result channel.
  typedef struct packed {
    logic [3:0] node;
    logic       chosen;
    logic       strict;
  } placement_t;

  // A row of the directed part: an optional node count write, the request,
  // and, for rows whose answer is plain, the placement typed in by hand.
  typedef struct {
    int         cfg;
    alloc_req_t req;
    bit         typed;
    placement_t want;
  } step_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  npr_req_if request ();
  npr_res_if result ();

  numa_policy_node_resolver_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (request),
    .result    (result)
  );

  // Shadow copy of the node count register and of the per-task policy table.
  logic [4:0]  node_count_q;
  logic [2:0]  task_mode_q   [npr_pkg::TASK_SLOTS_DEF];
  logic [15:0] task_mask_q   [npr_pkg::TASK_SLOTS_DEF];
  logic [3:0]  task_cursor_q [npr_pkg::TASK_SLOTS_DEF];

  // Placements still owed by the block, oldest first.
  placement_t expected_placements[$];

  step_row_t   directed_rows[$];
  int          fault_count  = 0;
  int          results_seen = 0;
  int          burst_left   = 4;
  int unsigned cycle_count  = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LINES) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Placement predictor
  // ---------------------------------------------------------------------------

  // Lowest set bit of the whole mask, or -1 when it is empty.
  function automatic int lowest_set(input logic [15:0] mask);
    for (int i = 0; i < npr_pkg::MAX_NODES; i++) begin
      if (mask[i]) return i;
    end
    return -1;
  endfunction

  // Round-robin search over nodes 0..n-1 from cur. On a hit, cur moves just
  // past the node found; mask bits at or above n never match.
  function automatic int next_interleave(input logic [15:0] mask, inout int unsigned cur,
                                         input int unsigned n);
    int unsigned i;
    for (int unsigned k = 0; k < n; k++) begin
      i = (cur + k) % n;
      if (mask[i]) begin
        cur = (i + 1) % n;
        return int'(i);
      end
    end
    return -1;
  endfunction

  // One policy lookup. A bind marks the decision strict even when its mask
  // is empty and nothing comes out of it.
  function automatic int policy_pick(input logic [2:0] mode, input logic [15:0] mask,
                                     inout int unsigned cur, input int unsigned n,
                                     input logic [3:0] local_nd, inout bit is_strict);
    case (mode)
      npr_pkg::MODE_BIND: begin
        is_strict = 1'b1;
        return lowest_set(mask);
      end
      npr_pkg::MODE_PREFERRED, npr_pkg::MODE_PREFERRED_MANY: begin
        return (mask != '0) ? lowest_set(mask) : int'(local_nd);
      end
      npr_pkg::MODE_INTERLEAVE, npr_pkg::MODE_WEIGHTED: begin
        return next_interleave(mask, cur, n);
      end
      npr_pkg::MODE_LOCAL: begin
        return int'(local_nd);
      end
      default: begin
        return -1;
      end
    endcase
  endfunction

  // Works out the placement for one accepted request and applies its effect
  // on the task table. Requests other than a resolve answer all zero.
  function automatic placement_t choose_node(input alloc_req_t r);
    placement_t  o;
    int          nd;
    int unsigned n;
    int unsigned cur;
    bit          is_strict;
    o         = '0;
    nd        = -1;
    is_strict = 1'b0;
    case (r.kind)
      npr_pkg::REQ_SET: begin
        task_mode_q[r.slot]   = r.pmode;
        task_mask_q[r.slot]   = r.pmask;
        task_cursor_q[r.slot] = '0;
        return o;
      end
      npr_pkg::REQ_CLEAR: begin
        task_mode_q[r.slot]   = npr_pkg::MODE_NONE;
        task_mask_q[r.slot]   = '0;
        task_cursor_q[r.slot] = '0;
        return o;
      end
      npr_pkg::REQ_RESOLVE: begin
      end
      default: begin
        return o;
      end
    endcase

    // Counts above the node limit saturate; one node or none leaves no choice.
    n = (node_count_q > npr_pkg::MAX_NODES) ? npr_pkg::MAX_NODES : node_count_q;
    if (n <= 1) return o;

    // Mapping policy first; its interleave is anchored on the page number.
    if (r.vmode != npr_pkg::MODE_NONE) begin
      cur = (r.vmask != '0) ? r.page : 0;
      nd  = policy_pick(r.vmode, r.vmask, cur, n, r.local_nd, is_strict);
    end
    // Then the home node, when it names a real node.
    if (nd < 0 && r.vhome != '0 && r.vhome <= npr_pkg::MAX_NODES) nd = int'(r.vhome) - 1;
    // Then the task policy, whose cursor is written back.
    if (nd < 0 && task_mode_q[r.slot] != npr_pkg::MODE_NONE) begin
      cur = task_cursor_q[r.slot];
      nd  = policy_pick(task_mode_q[r.slot], task_mask_q[r.slot], cur, n, r.local_nd,
                        is_strict);
      task_cursor_q[r.slot] = cur[3:0];
    end

    if (nd >= 0) begin
      o.node   = nd[3:0];
      o.chosen = 1'b1;
    end
    o.strict = is_strict;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Ends the current burst now and then: valid drops for a random gap, and
  // the next burst is usually short but sometimes a long unbroken run.
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      request.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  // Presents one item and holds it until it is taken. The expectation is
  // queued at the very edge the block accepts it, so the shadow table moves
  // in step with the block.
  task automatic offer(input alloc_req_t it, input bit typed, input placement_t want);
    placement_t pred;
    request.valid        <= 1'b1;
    request.req_type     <= it.kind;
    request.task_slot    <= it.slot;
    request.vma_mode     <= it.vmode;
    request.vma_nodes    <= it.vmask;
    request.vma_home     <= it.vhome;
    request.page_number  <= it.page;
    request.local_node   <= it.local_nd;
    request.policy_mode  <= it.pmode;
    request.policy_nodes <= it.pmask;
    @(posedge clk);
    while (request.ready !== 1'b1) @(posedge clk);
    pred = choose_node(it);
    expected_placements.push_back(typed ? want : pred);
    pace();
  endtask

  // Every item gives exactly one result, so an empty queue means the block
  // holds no work at all.
  task automatic settle();
    request.valid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
  endtask

  task automatic set_node_count(input logic [4:0] count);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we       <= 1'b0;
    node_count_q = count;
  endtask

  function automatic logic [15:0] random_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'(1) << $urandom_range(0, 15);
      2:       return '1;
      default: return 16'($urandom());
    endcase
  endfunction

  // Random request. Slots crowd onto a few entries so that set, clear and
  // resolve keep meeting the same policy, and many resolves are steered past
  // the mapping stage so that the task policy and its cursor get exercised.
  function automatic alloc_req_t random_request();
    alloc_req_t  r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)      r.kind = npr_pkg::REQ_RESOLVE;
    else if (roll < 82) r.kind = npr_pkg::REQ_SET;
    else if (roll < 95) r.kind = npr_pkg::REQ_CLEAR;
    else                r.kind = REQ_UNUSED;
    r.slot     = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom());
    r.vmode    = ($urandom_range(0, 9) < 3) ? npr_pkg::MODE_NONE : 3'($urandom());
    r.vmask    = random_mask();
    roll       = $urandom_range(0, 99);
    if (roll < 55)      r.vhome = '0;
    else if (roll < 90) r.vhome = 5'($urandom_range(1, 16));
    else                r.vhome = 5'($urandom_range(17, 31));
    r.page     = ($urandom_range(0, 9) != 0) ? 16'($urandom()) :
                 ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    r.local_nd = 4'($urandom());
    r.pmode    = 3'($urandom());
    r.pmask    = random_mask();
    if (r.kind == npr_pkg::REQ_RESOLVE && $urandom_range(0, 9) < 4) begin
      r.vmode = npr_pkg::MODE_NONE;
      r.vhome = '0;
    end
    return r;
  endfunction

  function automatic step_row_t row(input int cfg, input logic [1:0] kind,
                                    input logic [5:0] slot, input logic [2:0] vmode,
                                    input logic [15:0] vmask, input logic [4:0] vhome,
                                    input logic [15:0] page, input logic [3:0] local_nd,
                                    input logic [2:0] pmode, input logic [15:0] pmask,
                                    input bit typed, input logic [3:0] node,
                                    input bit chosen, input bit is_strict);
    step_row_t s;
    s.cfg   = cfg;
    s.req   = '{kind, slot, vmode, vmask, vhome, page, local_nd, pmode, pmask};
    s.typed = typed;
    s.want  = '{node, chosen, is_strict};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic check_placement();
    placement_t want;
    if (expected_placements.size() == 0) begin
      report($sformatf("unexpected result node=%0d chosen=%0b strict=%0b", result.node,
                       result.node_chosen, result.strict));
      return;
    end
    want = expected_placements.pop_front();
    if (result.node !== want.node)
      report($sformatf("result %0d: node %0d, want %0d", results_seen, result.node,
                       want.node));
    if (result.node_chosen !== want.chosen)
      report($sformatf("result %0d: node_chosen %0b, want %0b", results_seen,
                       result.node_chosen, want.chosen));
    if (result.strict !== want.strict)
      report($sformatf("result %0d: strict %0b, want %0b", results_seen, result.strict,
                       want.strict));
  endtask

  // Receiver: ready follows a rotating stall pattern, redrawn at random and sometimes
  // all ones. Twice during the run it holds off for a long stretch while the sender
  // keeps offering, so the output register fills and the block has to stall its input.
  initial begin
    int         hold_left;
    int         pattern_left;
    logic [7:0] pattern;
    hold_left    = 0;
    pattern_left = 0;
    pattern      = '1;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result.valid === 1'b1 && result.ready === 1'b1) begin
          check_placement();
          results_seen++;
          if (results_seen == 150 || results_seen == 900) hold_left = 300;
        end
        if (hold_left > 0) begin
          hold_left--;
          result.ready <= 1'b0;
        end else begin
          if (pattern_left == 0) begin
            pattern_left = $urandom_range(8, 64);
            pattern      = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h01);
          end
          pattern_left--;
          result.ready <= pattern[0];
          pattern      = {pattern[0], pattern[7:1]};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    logic [4:0] node_count_plan [12];

    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    request.valid        <= 1'b0;
    request.req_type     <= npr_pkg::REQ_RESOLVE;
    request.task_slot    <= '0;
    request.vma_mode     <= npr_pkg::MODE_NONE;
    request.vma_nodes    <= '0;
    request.vma_home     <= '0;
    request.page_number  <= '0;
    request.local_node   <= '0;
    request.policy_mode  <= npr_pkg::MODE_NONE;
    request.policy_nodes <= '0;

    node_count_q = 5'd1;
    for (int s = 0; s < npr_pkg::TASK_SLOTS_DEF; s++) begin
      task_mode_q[s]   = npr_pkg::MODE_NONE;
      task_mask_q[s]   = '0;
      task_cursor_q[s] = '0;
    end

    // Directed part. The first row runs at the reset node count of one, where
    // nothing may be chosen. Rows typed with 0,0,0 in the last three columns
    // and typed=0 are left to the predictor.
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 0, npr_pkg::MODE_BIND,
                                16'h0004, 0, 16'h0000, 3, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 0, 0));
    // Bind takes the lowest set bit, here the top node, and is strict.
    directed_rows.push_back(row(16, npr_pkg::REQ_RESOLVE, 0, npr_pkg::MODE_BIND,
                                16'h8000, 0, 16'h0000, 0, npr_pkg::MODE_NONE, 16'h0000,
                                1, 15, 1, 0 + 1));
    // Preferred with an empty mask falls back to the local node.
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 2, npr_pkg::MODE_PREFERRED,
                                16'h0000, 0, 16'h0000, 9, npr_pkg::MODE_NONE, 16'h0000,
                                1, 9, 1, 0));
    // Local wins before the home node is looked at.
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 2, npr_pkg::MODE_LOCAL,
                                16'hFFFF, 3, 16'hFFFF, 15, npr_pkg::MODE_NONE, 16'h0000,
                                1, 15, 1, 0));
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 2, npr_pkg::MODE_PREFERRED_MANY,
                                16'hFFFF, 0, 16'h0000, 4, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 1, 0));
    // Interleave on the mapping starts at the page number modulo the count.
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 2, npr_pkg::MODE_INTERLEAVE,
                                16'hFFFF, 0, 16'hFFFF, 0, npr_pkg::MODE_NONE, 16'h0000,
                                1, 15, 1, 0));
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 2, npr_pkg::MODE_WEIGHTED,
                                16'h0001, 0, 16'h1234, 6, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 1, 0));
    // An empty bind picks nothing but still makes the decision strict.
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 5, npr_pkg::MODE_BIND,
                                16'h0000, 0, 16'h0000, 2, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 0, 1));
    // Strict survives when the home node supplies the node.
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 5, npr_pkg::MODE_BIND,
                                16'h0000, 16, 16'h0000, 2, npr_pkg::MODE_NONE, 16'h0000,
                                1, 15, 1, 1));
    // The reserved mode is no policy, and a home past the last node is ignored.
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 5, MODE_RESERVED,
                                16'hFFFF, 17, 16'h0007, 2, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 0, 0));
    // Task interleave in the top slot; three resolves walk its cursor.
    directed_rows.push_back(row(-1, npr_pkg::REQ_SET, 63, npr_pkg::MODE_BIND,
                                16'hFFFF, 1, 16'hFFFF, 15, npr_pkg::MODE_INTERLEAVE,
                                16'hA5A5, 1, 0, 0, 0));
    repeat (3) begin
      directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 63, npr_pkg::MODE_NONE,
                                  16'hFFFF, 0, 16'h0000, 1, npr_pkg::MODE_NONE, 16'h0000,
                                  0, 0, 0, 0));
    end
    // The unused request type answers zero and leaves the table alone.
    directed_rows.push_back(row(-1, REQ_UNUSED, 63, npr_pkg::MODE_BIND,
                                16'hFFFF, 1, 16'hFFFF, 15, npr_pkg::MODE_BIND, 16'hFFFF,
                                1, 0, 0, 0));
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 63, npr_pkg::MODE_NONE,
                                16'h0000, 0, 16'h0000, 1, npr_pkg::MODE_NONE, 16'h0000,
                                0, 0, 0, 0));
    // The reserved mode is stored as given and then picks nothing.
    directed_rows.push_back(row(-1, npr_pkg::REQ_SET, 0, npr_pkg::MODE_NONE,
                                16'h0000, 0, 16'h0000, 0, MODE_RESERVED, 16'hFFFF,
                                1, 0, 0, 0));
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 0, npr_pkg::MODE_NONE,
                                16'h0000, 0, 16'h0000, 8, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 0, 0));
    // A cleared slot has no policy left.
    directed_rows.push_back(row(-1, npr_pkg::REQ_CLEAR, 63, npr_pkg::MODE_NONE,
                                16'h0000, 0, 16'h0000, 0, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 0, 0));
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 63, npr_pkg::MODE_NONE,
                                16'h0000, 0, 16'h0000, 3, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 0, 0));
    // With four nodes, interleave bits above the count are ignored ...
    directed_rows.push_back(row(4, npr_pkg::REQ_RESOLVE, 0, npr_pkg::MODE_INTERLEAVE,
                                16'hFFF0, 0, 16'h0003, 0, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 0, 0));
    // ... but bind still takes a bit above the count.
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 0, npr_pkg::MODE_BIND,
                                16'h8000, 0, 16'h0000, 0, npr_pkg::MODE_NONE, 16'h0000,
                                1, 15, 1, 1));
    // A count past the node limit acts as sixteen: page 17 lands on node 1.
    directed_rows.push_back(row(31, npr_pkg::REQ_RESOLVE, 0, npr_pkg::MODE_INTERLEAVE,
                                16'hFFFF, 0, 16'h0011, 0, npr_pkg::MODE_NONE, 16'h0000,
                                1, 1, 1, 0));
    // An empty task bind is strict with no node.
    directed_rows.push_back(row(-1, npr_pkg::REQ_SET, 1, npr_pkg::MODE_NONE,
                                16'h0000, 0, 16'h0000, 0, npr_pkg::MODE_BIND, 16'h0000,
                                1, 0, 0, 0));
    directed_rows.push_back(row(-1, npr_pkg::REQ_RESOLVE, 1, npr_pkg::MODE_NONE,
                                16'h0000, 0, 16'h0000, 0, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 0, 1));
    // A count of zero gives no choice at all.
    directed_rows.push_back(row(0, npr_pkg::REQ_RESOLVE, 2, npr_pkg::MODE_LOCAL,
                                16'h0000, 0, 16'h0000, 7, npr_pkg::MODE_NONE, 16'h0000,
                                1, 0, 0, 0));

    // Random phases, each at its own node count: the extremes, small odd
    // counts where the modulo matters, and one drawn at random.
    node_count_plan     = '{5'd16, 5'd2, 5'd3, 5'd0, 5'd5, 5'd17, 5'd31, 5'd8, 5'd1, 5'd7,
                            5'd16, 5'd4};
    node_count_plan[10] = 5'($urandom_range(2, 16));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The block runs its table clearing pass first; offer simply waits on
    // ready until it is done.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg >= 0) set_node_count(5'(directed_rows[i].cfg));
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    foreach (node_count_plan[p]) begin
      set_node_count(node_count_plan[p]);
      repeat (RANDOM_PER_PHASE) offer(random_request(), 1'b0, '0);
    end

    // Drain, then give any stray result time to show up.
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/npr_pkg.sv
design/npr_channels.sv
design/numa_policy_node_resolver_top.sv
tb/numa_policy_node_resolver_top_tb.sv
